// ----- sv/isrt_pkg.sv -----
// Shared constants and types for the insertion sorter.
package isrt_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DEPTH     = 64;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = IDX_W + 1;
  localparam int VAL_W     = 32;
  localparam int CMPC_W    = 11;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CMPC_W-1:0]       cmpc_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_ITEM,
    ST_CMP,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

  typedef struct packed {
    logic   valid;
    value_t sorted_value;
    logic   is_last;
    cmpc_t  comparison_count;
    logic   overflow;
  } emit_t;

endpackage

// ----- sv/isrt_if.sv -----
// Valid/ready channel interfaces for the sorter input and result streams.
interface isrt_in_if;
  import isrt_pkg::*;
  logic   valid;
  logic   ready;
  value_t value;
  logic   last;
  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface isrt_out_if;
  import isrt_pkg::*;
  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   is_last;
  cmpc_t  comparison_count;
  logic   overflow;
  modport source (output valid, output sorted_value, output is_last,
                  output comparison_count, output overflow, input ready);
  modport sink   (input valid, input sorted_value, input is_last,
                  input comparison_count, input overflow, output ready);
endinterface

// ----- sv/isrt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module isrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/isrt_core.sv -----
// Load, sort and read-out sequencer around the element store and one compare unit.
module isrt_core (
  input  logic            clk,
  input  logic            rst_n,
  isrt_in_if.sink         in_chan,
  output isrt_pkg::emit_t emit,
  input  logic            emit_ready
);
  import isrt_pkg::*;

  state_t state_r, state_nxt;
  count_t count_r, count_nxt;
  count_t i_r, i_nxt;
  count_t pos_r, pos_nxt;
  count_t k_r, k_nxt;
  cmpc_t  cmp_r, cmp_nxt;
  logic   ovf_r, ovf_nxt;
  value_t item_r, item_nxt;

  logic   we;
  idx_t   waddr, raddr;
  value_t wdata, rd_data;

  logic   accept, room, gt, more, fin;
  count_t load_count;

  isrt_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign accept     = in_chan.valid && in_chan.ready;
  assign room       = count_r < CNT_W'(MAX_ITEMS);
  assign load_count = room ? count_r + count_t'(1) : count_r;
  // shared compare unit: stored neighbor against the item being inserted
  assign gt         = rd_data > item_r;
  assign more       = (i_r + count_t'(1)) < count_r;
  assign fin        = (k_r + count_t'(1)) == count_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (accept && in_chan.last) begin
          state_nxt = (load_count > count_t'(1)) ? ST_FETCH : ST_EMIT_RD;
        end
      end
      ST_FETCH: state_nxt = ST_ITEM;
      ST_ITEM:  state_nxt = ST_CMP;
      ST_CMP: begin
        if (gt) begin
          state_nxt = (pos_r == count_t'(1)) ? ST_PLACE : ST_CMP;
        end else begin
          state_nxt = more ? ST_FETCH : ST_EMIT_RD;
        end
      end
      ST_PLACE:   state_nxt = more ? ST_FETCH : ST_EMIT_RD;
      ST_EMIT_RD: state_nxt = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (emit_ready) begin
          state_nxt = fin ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs: store port and result request
  always_comb begin
    in_chan.ready         = 1'b0;
    we                    = 1'b0;
    waddr                 = '0;
    wdata                 = in_chan.value;
    raddr                 = '0;
    emit.valid            = 1'b0;
    emit.sorted_value     = rd_data;
    emit.is_last          = fin;
    emit.comparison_count = fin ? cmp_r : '0;
    emit.overflow         = ovf_r;
    case (state_r)
      ST_LOAD: begin
        in_chan.ready = 1'b1;
        we            = accept && room;
        waddr         = count_r[IDX_W-1:0];
      end
      ST_FETCH: raddr = i_r[IDX_W-1:0];
      ST_ITEM:  raddr = i_r[IDX_W-1:0] - idx_t'(1);
      ST_CMP: begin
        // look ahead one slot so the next neighbor is read while this one is compared
        raddr = pos_r[IDX_W-1:0] - idx_t'(2);
        we    = 1'b1;
        waddr = pos_r[IDX_W-1:0];
        wdata = gt ? rd_data : item_r;
      end
      ST_PLACE: begin
        we    = 1'b1;
        waddr = pos_r[IDX_W-1:0];
        wdata = item_r;
      end
      ST_EMIT_RD: raddr = k_r[IDX_W-1:0];
      ST_EMIT_WR: begin
        // hold the read address so a stalled request keeps its value
        raddr      = k_r[IDX_W-1:0];
        emit.valid = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    count_nxt = count_r;
    i_nxt     = i_r;
    pos_nxt   = pos_r;
    k_nxt     = k_r;
    cmp_nxt   = cmp_r;
    ovf_nxt   = ovf_r;
    item_nxt  = item_r;
    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          count_nxt = load_count;
          if (!room) begin
            ovf_nxt = 1'b1;
          end
          if (in_chan.last) begin
            i_nxt = count_t'(1);
            k_nxt = '0;
          end
        end
      end
      ST_ITEM: begin
        item_nxt = rd_data;
        pos_nxt  = i_r;
      end
      ST_CMP: begin
        cmp_nxt = cmp_r + cmpc_t'(1);
        if (gt) begin
          pos_nxt = pos_r - count_t'(1);
        end else if (more) begin
          i_nxt = i_r + count_t'(1);
        end
      end
      ST_PLACE: begin
        if (more) begin
          i_nxt = i_r + count_t'(1);
        end
      end
      ST_EMIT_WR: begin
        if (emit_ready) begin
          k_nxt = k_r + count_t'(1);
          if (fin) begin
            count_nxt = '0;
            cmp_nxt   = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      i_r     <= '0;
      pos_r   <= '0;
      k_r     <= '0;
      cmp_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      i_r     <= i_nxt;
      pos_r   <= pos_nxt;
      k_r     <= k_nxt;
      cmp_r   <= cmp_nxt;
      ovf_r   <= ovf_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

// ----- sv/insertion_sorter_top.sv -----
// Insertion sorter top level: sequencer core plus the result output register.
//
// in_chan (valid/ready) takes one signed 32-bit value per request; the request
// with last set closes the set. Up to 64 values are kept; further requests are
// dropped and the run reports overflow on every result. A dropped request that
// carries last still closes the set.
// After the closing request the block sorts ascending (stable for equal values)
// and emits the values in order on out_chan. The final result has is_last set
// and carries the number of comparisons; earlier results carry zero there.
// Loading takes requests back to back. For each value after the first, the
// sort fetches the value and its left neighbor from the store, then compares
// it with one stored neighbor per step, shifting larger ones up; a value that
// moves all the way to the front takes one more step to be placed. The single
// store read port and the one compare per cycle set this pace. Each result is
// read from the store, then loaded into the output register.
// in_chan.ready is high only while loading; it rises as soon as the final
// result sits in the output register. A stalled receiver holds the output
// register and pauses the read-out. Reset (rst_n low, synchronous) empties
// the set and clears the counters; stored values need no clearing.
module insertion_sorter_top (
  input  logic       clk,
  input  logic       rst_n,
  isrt_in_if.sink    in_chan,
  isrt_out_if.source out_chan
);
  import isrt_pkg::*;

  emit_t emit;
  logic  emit_ready;
  logic  out_valid_r, out_valid_nxt;
  emit_t out_r, out_nxt;

  isrt_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .emit       (emit),
    .emit_ready (emit_ready)
  );

  assign emit_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (emit_ready) begin
      out_valid_nxt = emit.valid;
      if (emit.valid) begin
        out_nxt = emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.sorted_value     = out_r.sorted_value;
  assign out_chan.is_last          = out_r.is_last;
  assign out_chan.comparison_count = out_r.comparison_count;
  assign out_chan.overflow         = out_r.overflow;

endmodule

// ----- sv/isrt_chk.sv -----
// Port-level assertions for the insertion sorter, bound to the top level.
module isrt_chk (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_last,
  input logic                    out_valid,
  input logic                    out_ready,
  input isrt_pkg::value_t        out_sorted_value,
  input logic                    out_is_last,
  input isrt_pkg::cmpc_t         out_comparison_count
);
  import isrt_pkg::*;

  // closing request starts the sort, so no further request is taken
  a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after closing request");

  // read-out and loading never overlap before the final result
  a_emit_not_loading: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |-> !in_ready)
    else $error("input ready during read-out");

  a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |-> out_comparison_count == '0)
    else $error("comparison count on non-final result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sorted_value))
    else $error("stalled result changed");

endmodule

bind insertion_sorter_top isrt_chk u_isrt_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_chan.valid),
  .in_ready             (in_chan.ready),
  .in_last              (in_chan.last),
  .out_valid            (out_chan.valid),
  .out_ready            (out_chan.ready),
  .out_sorted_value     (out_chan.sorted_value),
  .out_is_last          (out_chan.is_last),
  .out_comparison_count (out_chan.comparison_count)
);

// ----- verif/insertion_sorter_top_tb.sv -----
// Testbench for insertion_sorter_top: stable ascending sort of value sets, with random pacing.
module insertion_sorter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import isrt_pkg::*;

  localparam int ITEM_TARGET    = 320;
  localparam int QUIET_LIMIT    = 20000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int LONG_HOLD      = 400;
  localparam value_t VAL_MAX    = {1'b0, {(VAL_W-1){1'b1}}};
  localparam value_t VAL_MIN    = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct {
    value_t value;
    logic   is_last;
    cmpc_t  comps;
    logic   ovf;
  } sorted_result_t;

  logic clk = 1'b0;
  logic rst_n;

  isrt_in_if  in_ch();
  isrt_out_if out_ch();

  insertion_sorter_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  always #1 clk = ~clk;

  // Model state: values of the set being loaded, and results still owed.
  value_t         staged [DEPTH];
  int             staged_cnt = 0;
  logic           staged_ovf = 1'b0;
  sorted_result_t sorted_expect[$];

  int   mismatch_count  = 0;
  int   items_sent      = 0;
  int   hold_off_cycles = 0;
  logic tx_idle_en      = 1'b1;
  logic rx_idle_en      = 1'b1;

  function automatic void predict_request(value_t v, logic lst);
    value_t         key;
    int             pos;
    cmpc_t          tally;
    sorted_result_t r;
    if (staged_cnt < MAX_ITEMS) begin
      staged[staged_cnt] = v;
      staged_cnt++;
    end else begin
      staged_ovf = 1'b1;
    end
    if (!lst) return;
    tally = '0;
    for (int i = 1; i < staged_cnt; i++) begin
      key = staged[i];
      pos = i;
      // every probe counts, including the one that stops the scan
      while (pos > 0) begin
        tally = tally + 1'b1;
        if (staged[pos-1] <= key) break;
        staged[pos] = staged[pos-1];
        pos--;
      end
      staged[pos] = key;
    end
    for (int k = 0; k < staged_cnt; k++) begin
      r.value   = staged[k];
      r.is_last = (k == staged_cnt - 1);
      r.comps   = r.is_last ? tally : '0;
      r.ovf     = staged_ovf;
      sorted_expect.push_back(r);
    end
    staged_cnt = 0;
    staged_ovf = 1'b0;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      predict_request(in_ch.value, in_ch.last);
  end

  always @(posedge clk) begin : result_check
    sorted_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sorted_expect.size() == 0) begin
        $error("unexpected result: sorted_value %0d", out_ch.sorted_value);
        mismatch_count++;
      end else begin
        want = sorted_expect.pop_front();
        if (out_ch.sorted_value !== want.value) begin
          $error("sorted_value: expected %0d, got %0d", want.value, out_ch.sorted_value);
          mismatch_count++;
        end
        if (out_ch.is_last !== want.is_last) begin
          $error("is_last: expected %0b, got %0b", want.is_last, out_ch.is_last);
          mismatch_count++;
        end
        if (out_ch.comparison_count !== want.comps) begin
          $error("comparison_count: expected %0d, got %0d", want.comps,
                 out_ch.comparison_count);
          mismatch_count++;
        end
        if (out_ch.overflow !== want.ovf) begin
          $error("overflow: expected %0b, got %0b", want.ovf, out_ch.overflow);
          mismatch_count++;
        end
      end
    end
  end

  // Result side: random stall after each result, plus the long hold when asked.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        stall_left = rx_idle_en ? $urandom_range(0, 9) : 0;
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("insertion_sorter_top_tb failed");
      $finish;
    end
  end

  // Call at a rising edge; returns at the edge where the request is taken.
  task automatic send_value(input value_t v, input logic lst);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_set(input value_t vals[$]);
    foreach (vals[i])
      send_value(vals[i], i == vals.size() - 1);
  endtask

  function automatic value_t pick_value(int mode);
    case (mode)
      0: return value_t'($urandom);
      1: return value_t'($urandom_range(0, 8)) - 4;
      default: begin
        case ($urandom_range(0, 4))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          3: return '1;
          default: return value_t'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic test_single_value();
    value_t vals[$];
    vals = '{value_t'(0)};
    send_set(vals);
    vals = '{VAL_MAX};
    send_set(vals);
    vals = '{VAL_MIN};
    send_set(vals);
  endtask

  task automatic test_extremes();
    value_t vals[$];
    vals = '{VAL_MAX, VAL_MIN, value_t'(0), value_t'(-1), value_t'(1)};
    send_set(vals);
  endtask

  task automatic test_ordering();
    value_t vals[$];
    vals = '{value_t'(-3), value_t'(-2), value_t'(7), value_t'(9)};
    send_set(vals);
    vals = '{value_t'(5), value_t'(3), value_t'(1), value_t'(-1), value_t'(-3)};
    send_set(vals);
    // equal values must not move past each other
    vals = '{value_t'(2), value_t'(-1), value_t'(2), value_t'(-1), value_t'(2)};
    send_set(vals);
  endtask

  task automatic test_full_capacity();
    value_t vals[$];
    vals.delete();
    for (int i = 0; i < MAX_ITEMS; i++)
      vals.push_back(VAL_MAX - value_t'(i));
    send_set(vals);
    vals.delete();
    for (int i = 0; i < MAX_ITEMS; i++)
      vals.push_back(VAL_MIN + value_t'(i));
    send_set(vals);
  endtask

  task automatic test_overflow();
    value_t vals[$];
    vals.delete();
    for (int i = 0; i < MAX_ITEMS + 2; i++)
      vals.push_back(pick_value(0));
    send_set(vals);
    vals.delete();
    for (int i = 0; i < MAX_ITEMS + 1; i++)
      vals.push_back(pick_value(1));
    send_set(vals);
  endtask

  task automatic test_backpressure();
    value_t vals[$];
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_off_cycles = LONG_HOLD;
    repeat (3) begin
      vals.delete();
      for (int i = 0; i < 12; i++)
        vals.push_back(pick_value($urandom_range(0, 2)));
      send_set(vals);
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_random_sets();
    value_t vals[$];
    int     set_len;
    int     mode;
    while (items_sent < ITEM_TARGET) begin
      // mostly short sets; now and then one near, at or past capacity
      if ($urandom_range(0, 19) == 0)
        set_len = $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6);
      else
        set_len = $urandom_range(1, 12);
      mode = $urandom_range(0, 2);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      vals.delete();
      for (int i = 0; i < set_len; i++)
        vals.push_back(pick_value(mode));
      send_set(vals);
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.last  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_single_value();
    test_extremes();
    test_ordering();
    test_full_capacity();
    test_overflow();
    test_backpressure();
    test_random_sets();

    in_ch.valid <= 1'b0;
    while (sorted_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && sorted_expect.size() == 0) begin
      $display("insertion_sorter_top_tb passed");
    end else begin
      $display("insertion_sorter_top_tb failed");
    end
    $finish;
  end

endmodule
